[rtl/assert_macros.svh]
// Assertion macros shared by the sequencer modules.
// Needs nothing else; taken in by `include where a module asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// A condition that must hold in the same cycle as a trigger.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ttk_pkg.sv]
// Package of the text to keyboard report sequencer: payload types,
// request and shift mode codes, queued command type and size constants.
// Depends on nothing.
`timescale 1ns / 1ps

package ttk_pkg;

  // Default size of the character table and the keymap usage limit.
  localparam int CHAR_TABLE_DEPTH = 256;
  localparam int KEYMAP_DEPTH     = 256;

  // Entries of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Request type codes.
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_TEXT  = 2'd2;

  // Shift modes stored with each table entry.
  localparam logic [1:0] MODE_UP   = 2'd0;
  localparam logic [1:0] MODE_DOWN = 2'd1;
  localparam logic [1:0] MODE_ANY  = 2'd2;

  // Width of one table word: usage then shift mode.
  localparam int ENTRY_W = 10;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] usage;
    logic [7:0] plain_char;
    logic [7:0] shifted_char;
    logic [7:0] text_char;
    logic       text_end;
  } request_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic       shift_down;
    logic       failed;
    logic       last;
  } report_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_LOAD  = 2'd2,
    OP_TEXT  = 2'd3
  } op_t;

  // Classified command as it travels through the queue.
  typedef struct packed {
    op_t        op;
    logic [7:0] usage;
    logic       plain_we;
    logic [7:0] plain_char;
    logic [1:0] plain_mode;
    logic       shifted_we;
    logic [7:0] shifted_char;
    logic [7:0] text_char;
    logic       in_range;
    logic       text_end;
  } cmd_t;

endpackage

[rtl/ttk_ram.sv]
// Generic simple dual port RAM: one write port, one read port with
// registered read data. Depends on nothing.
`timescale 1ns / 1ps

module ttk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ttk_front.sv]
// Front of the sequencer: accepts requests, classifies them into commands
// and hands them to the queue. Depends on ttk_pkg.
`timescale 1ns / 1ps

module ttk_front #(
  parameter int CHAR_TABLE_DEPTH = ttk_pkg::CHAR_TABLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ttk_pkg::request_t request,
  input  logic              q_full,
  output logic              push,
  output ttk_pkg::cmd_t     push_cmd
);

  logic          stage_valid;
  logic          stage_valid_next;
  ttk_pkg::cmd_t stage_cmd;
  ttk_pkg::cmd_t cls;
  logic          accept;
  logic          usage_ok;
  logic          plain_ok;
  logic          shifted_ok;
  logic          text_ok;

  // Range checks on usage and characters.
  assign usage_ok   = (request.usage != 8'd0) &&
                      ({1'b0, request.usage} < 9'(ttk_pkg::KEYMAP_DEPTH));
  assign plain_ok   = (request.plain_char != 8'd0) &&
                      ({1'b0, request.plain_char} < 9'(CHAR_TABLE_DEPTH));
  assign shifted_ok = (request.shifted_char != 8'd0) &&
                      (request.shifted_char != request.plain_char) &&
                      ({1'b0, request.shifted_char} < 9'(CHAR_TABLE_DEPTH));
  assign text_ok    = {1'b0, request.text_char} < 9'(CHAR_TABLE_DEPTH);

  // Classification of the request into a command.
  always_comb begin
    cls              = '0;
    cls.op           = ttk_pkg::OP_NONE;
    cls.usage        = request.usage;
    cls.plain_char   = request.plain_char;
    cls.shifted_char = request.shifted_char;
    cls.text_char    = request.text_char;
    cls.text_end     = request.text_end;
    cls.in_range     = text_ok;
    cls.plain_mode   = (request.plain_char == request.shifted_char) ?
                       ttk_pkg::MODE_ANY : ttk_pkg::MODE_UP;
    case (request.req_type)
      ttk_pkg::REQ_CLEAR: begin
        cls.op = ttk_pkg::OP_CLEAR;
      end
      ttk_pkg::REQ_LOAD: begin
        cls.plain_we   = usage_ok && plain_ok;
        cls.shifted_we = usage_ok && shifted_ok;
        if (usage_ok && (plain_ok || shifted_ok)) begin
          cls.op = ttk_pkg::OP_LOAD;
        end
      end
      ttk_pkg::REQ_TEXT: begin
        cls.op = ttk_pkg::OP_TEXT;
      end
      default: begin
        cls.op = ttk_pkg::OP_NONE;
      end
    endcase
  end

  // Handshake: the stage holds one command until the queue takes it.
  assign busy     = stage_valid && q_full;
  assign accept   = start && !busy;
  assign push     = stage_valid && !q_full;
  assign push_cmd = stage_cmd;

  always_comb begin
    stage_valid_next = stage_valid;
    if (accept) begin
      stage_valid_next = (cls.op != ttk_pkg::OP_NONE);
    end else if (push) begin
      stage_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  // Command payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_cmd <= cls;
    end
  end

endmodule

[rtl/ttk_queue.sv]
// Short command queue between the front and the back of the sequencer.
// Depends on ttk_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ttk_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ttk_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output ttk_pkg::cmd_t head
);

  localparam int DEPTH = ttk_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ttk_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, clk, rst, !(push && full))
  `ASSERT_ALWAYS(a_no_underflow, clk, rst, !(pop && !head_valid))
  `ASSERT_ALWAYS(a_count_range, clk, rst, count <= CNT_W'(DEPTH))

endmodule

[rtl/ttk_back.sv]
// Back of the sequencer: runs queued commands against the character table
// and sends keyboard reports. Depends on ttk_pkg, ttk_ram, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ttk_back #(
  parameter int CHAR_TABLE_DEPTH = ttk_pkg::CHAR_TABLE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  ttk_pkg::cmd_t    head,
  output logic             pop,
  output logic             strobe,
  output ttk_pkg::report_t result
);

  localparam int IDX_W = $clog2(CHAR_TABLE_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD2 = 5'b00010,
    ST_LOOK  = 5'b00100,
    ST_KEY   = 5'b01000,
    ST_END   = 5'b10000
  } state_t;

  state_t                        state;
  state_t                        state_next;
  ttk_pkg::cmd_t                 cmd;
  logic [CHAR_TABLE_DEPTH-1:0]   valid_bits;
  logic                          shift_held;
  logic                          shift_held_next;
  logic [7:0]                    held_key;
  logic [7:0]                    held_key_next;
  logic                          discarding;
  logic                          discarding_next;
  logic [7:0]                    key;
  logic [7:0]                    key_next;
  logic                          strobe_next;
  ttk_pkg::report_t              result_next;
  logic                          table_clear;
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [ttk_pkg::ENTRY_W-1:0]   ram_wdata;
  logic [ttk_pkg::ENTRY_W-1:0]   ram_rdata;
  logic [7:0]                    rd_usage;
  logic [1:0]                    rd_mode;
  logic                          hit;

  // Usage and shift mode of every character.
  ttk_ram #(
    .WIDTH (ttk_pkg::ENTRY_W),
    .DEPTH (CHAR_TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head.text_char[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_usage = ram_rdata[ttk_pkg::ENTRY_W-1:2];
  assign rd_mode  = ram_rdata[1:0];
  assign hit      = head.in_range && valid_bits[head.text_char[IDX_W-1:0]];
  assign pop      = (state == ST_IDLE) && head_valid;

  // Sequencer: one command at a time, at most one report per cycle.
  always_comb begin
    state_next      = state;
    shift_held_next = shift_held;
    held_key_next   = held_key;
    discarding_next = discarding;
    key_next        = key;
    strobe_next     = 1'b0;
    result_next     = '0;
    table_clear     = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = head.plain_char[IDX_W-1:0];
    ram_wdata       = {head.usage, head.plain_mode};
    case (state)
      ST_IDLE: begin
        if (head_valid) begin
          case (head.op)
            ttk_pkg::OP_CLEAR: begin
              table_clear = 1'b1;
            end
            ttk_pkg::OP_LOAD: begin
              ram_we = head.plain_we;
              if (head.shifted_we) begin
                state_next = ST_LOAD2;
              end
            end
            ttk_pkg::OP_TEXT: begin
              if (discarding) begin
                if (head.text_end) begin
                  discarding_next = 1'b0;
                end
              end else if (!hit) begin
                // Unmapped character: error report closes the text.
                strobe_next        = 1'b1;
                result_next.failed = 1'b1;
                result_next.last   = 1'b1;
                shift_held_next    = 1'b0;
                held_key_next      = 8'd0;
                discarding_next    = !head.text_end;
              end else begin
                state_next = ST_LOOK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD2: begin
        ram_we     = 1'b1;
        ram_waddr  = cmd.shifted_char[IDX_W-1:0];
        ram_wdata  = {cmd.usage, ttk_pkg::MODE_DOWN};
        state_next = ST_IDLE;
      end
      ST_LOOK: begin
        // Table word is here; send a shift change or a release first.
        key_next    = rd_usage;
        strobe_next = 1'b1;
        state_next  = ST_KEY;
        if ((rd_mode == ttk_pkg::MODE_DOWN) && !shift_held) begin
          shift_held_next        = 1'b1;
          held_key_next          = 8'd0;
          result_next.shift_down = 1'b1;
        end else if ((rd_mode == ttk_pkg::MODE_UP) && shift_held) begin
          shift_held_next = 1'b0;
          held_key_next   = 8'd0;
        end else if (held_key == rd_usage) begin
          held_key_next          = 8'd0;
          result_next.shift_down = shift_held;
        end else begin
          result_next.key_code   = rd_usage;
          result_next.shift_down = shift_held;
          held_key_next          = rd_usage;
          state_next             = cmd.text_end ? ST_END : ST_IDLE;
        end
      end
      ST_KEY: begin
        strobe_next            = 1'b1;
        result_next.key_code   = key;
        result_next.shift_down = shift_held;
        held_key_next          = key;
        state_next             = cmd.text_end ? ST_END : ST_IDLE;
      end
      ST_END: begin
        strobe_next      = 1'b1;
        result_next.last = 1'b1;
        shift_held_next  = 1'b0;
        held_key_next    = 8'd0;
        state_next       = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state and table valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      shift_held <= 1'b0;
      held_key   <= 8'd0;
      discarding <= 1'b0;
      strobe     <= 1'b0;
      valid_bits <= '0;
    end else begin
      state      <= state_next;
      shift_held <= shift_held_next;
      held_key   <= held_key_next;
      discarding <= discarding_next;
      strobe     <= strobe_next;
      if (table_clear) begin
        valid_bits <= '0;
      end else if (ram_we) begin
        valid_bits[ram_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
    key    <= key_next;
    result <= result_next;
  end

  `ASSERT_IMPLIES(a_last_idle_keys, clk, rst, strobe && result.last,
                  !shift_held && (held_key == 8'd0))
  `ASSERT_IMPLIES(a_fail_is_final, clk, rst, strobe && result.failed,
                  result.last && (result.key_code == 8'd0) && !result.shift_down)
  `ASSERT_IMPLIES(a_look_after_pop, clk, rst, state == ST_LOOK,
                  $past(pop) && ($past(head.op) == ttk_pkg::OP_TEXT))

endmodule

[rtl/text_to_keyboard_report_sequencer.sv]
// Top level of the text to keyboard report sequencer.
// Depends on ttk_pkg, ttk_front, ttk_queue and ttk_back.
`timescale 1ns / 1ps

// Requests are transferred when start is high and busy is low. A front
// stage classifies each request and a two-entry queue holds it for the
// back, so up to three requests may wait while the back works. Requests
// that have no effect (unknown type, or a keymap entry that stores nothing)
// are dropped by the front and never reach the back. The back takes one
// command at a time: a table clear, a keymap entry and a discarded or
// unmapped text character are handled in the idle state, plus ST_LOAD2
// when a shifted character is stored. A mapped character reads the
// table, whose read data is registered, in the idle state; ST_LOOK and,
// as needed, ST_KEY and ST_END then send its one to three reports.
// Reports leave on result, one per cycle with strobe high for that cycle
// only; the receiver cannot hold them off and must take each one. The
// table valid bits clear at once on reset and on a clear request.
module text_to_keyboard_report_sequencer #(
  parameter int CHAR_TABLE_DEPTH = ttk_pkg::CHAR_TABLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ttk_pkg::request_t request,
  output logic              strobe,
  output ttk_pkg::report_t  result
);

  logic          q_full;
  logic          push;
  ttk_pkg::cmd_t push_cmd;
  logic          pop;
  logic          head_valid;
  ttk_pkg::cmd_t head;

  // Request intake and classification.
  ttk_front #(
    .CHAR_TABLE_DEPTH (CHAR_TABLE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Command queue.
  ttk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Table and report sequencer.
  ttk_back #(
    .CHAR_TABLE_DEPTH (CHAR_TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .strobe     (strobe),
    .result     (result)
  );

endmodule

[verif/tb.sv]
// Self-checking testbench of the text to keyboard report sequencer.
// Depends on ttk_pkg and the top level; a directed table, then random requests.
`timescale 1ns / 1ps

module tb;

  // Request code that the block ignores.
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  localparam int TABLE_DEPTH  = ttk_pkg::CHAR_TABLE_DEPTH;
  localparam int KEYMAP_LIMIT = ttk_pkg::KEYMAP_DEPTH;
  localparam int RANDOM_ITEMS = 430;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 200000;

  // How the expectation of a directed row is formed.
  typedef enum int {
    ROW_PREDICTED,
    ROW_SILENT,
    ROW_FAULT
  } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    ttk_pkg::request_t req;
  } directed_row_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  ttk_pkg::request_t request;
  logic              strobe;
  ttk_pkg::report_t  result;

  // Character table and text state as the block should hold them.
  bit          char_valid [256];
  logic [7:0]  char_usage [256];
  logic [1:0]  char_mode [256];
  logic        shift_held;
  logic [7:0]  held_key;
  logic        discarding;

  ttk_pkg::report_t step_reports [$];
  ttk_pkg::report_t expected_reports [$];
  directed_row_t    directed_rows [$];

  int          error_count = 0;
  int          sent_count = 0;
  int          stretch_left = 0;
  bit          no_gap = 1'b0;
  int unsigned cycle_count = 0;

  text_to_keyboard_report_sequencer i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  // Free-running clock of 10 ns.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Appends one report to the output of the current step.
  task automatic add_report(input logic [7:0] key, input logic shift, input logic fail,
                            input logic fin);
    ttk_pkg::report_t rep;
    rep.key_code   = key;
    rep.shift_down = shift;
    rep.failed     = fail;
    rep.last       = fin;
    step_reports   = {step_reports, rep};
  endtask

  task automatic store_char(input logic [7:0] ch, input logic [7:0] usage,
                            input logic [1:0] mode);
    if (int'(ch) < TABLE_DEPTH) begin
      char_valid[ch] = 1'b1;
      char_usage[ch] = usage;
      char_mode[ch]  = mode;
    end
  endtask

  // Works out the reports caused by one transfer and updates the state.
  task automatic step_sequencer(input ttk_pkg::request_t r);
    logic [7:0] key;
    logic [1:0] mode;
    step_reports.delete();
    case (r.req_type)
      ttk_pkg::REQ_CLEAR: begin
        foreach (char_valid[c]) char_valid[c] = 1'b0;
      end
      ttk_pkg::REQ_LOAD: begin
        if (r.usage != 8'd0 && int'(r.usage) < KEYMAP_LIMIT) begin
          if (r.plain_char != 8'd0)
            store_char(r.plain_char, r.usage,
                       (r.plain_char == r.shifted_char) ? ttk_pkg::MODE_ANY :
                                                          ttk_pkg::MODE_UP);
          if (r.shifted_char != 8'd0 && r.shifted_char != r.plain_char)
            store_char(r.shifted_char, r.usage, ttk_pkg::MODE_DOWN);
        end
      end
      ttk_pkg::REQ_TEXT: begin
        if (discarding) begin
          // The rest of a failed text is dropped up to its final character.
          if (r.text_end) discarding = 1'b0;
        end else if (int'(r.text_char) >= TABLE_DEPTH || !char_valid[r.text_char]) begin
          add_report(8'd0, 1'b0, 1'b1, 1'b1);
          shift_held = 1'b0;
          held_key   = 8'd0;
          discarding = !r.text_end;
        end else begin
          key  = char_usage[r.text_char];
          mode = char_mode[r.text_char];
          if (mode == ttk_pkg::MODE_DOWN && !shift_held) begin
            shift_held = 1'b1;
            held_key   = 8'd0;
            add_report(8'd0, 1'b1, 1'b0, 1'b0);
          end else if (mode == ttk_pkg::MODE_UP && shift_held) begin
            shift_held = 1'b0;
            held_key   = 8'd0;
            add_report(8'd0, 1'b0, 1'b0, 1'b0);
          end else if (held_key == key) begin
            held_key = 8'd0;
            add_report(8'd0, shift_held, 1'b0, 1'b0);
          end
          add_report(key, shift_held, 1'b0, 1'b0);
          held_key = key;
          if (r.text_end) begin
            add_report(8'd0, 1'b0, 1'b0, 1'b1);
            shift_held = 1'b0;
            held_key   = 8'd0;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Drives one request after a random gap and waits for its transfer.
  task automatic send_request(input ttk_pkg::request_t r, input row_kind_t kind);
    int               gap;
    ttk_pkg::report_t fault;
    if (stretch_left == 0) begin
      no_gap       = ($urandom_range(0, 3) == 0);
      stretch_left = int'($urandom_range(20, 60));
    end
    stretch_left--;
    gap = no_gap ? 0 : int'($urandom_range(0, 8));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy !== 1'b0);
    step_sequencer(r);
    case (kind)
      ROW_PREDICTED: begin
        foreach (step_reports[k]) expected_reports = {expected_reports, step_reports[k]};
      end
      ROW_FAULT: begin
        fault = '{key_code: 8'd0, shift_down: 1'b0, failed: 1'b1, last: 1'b1};
        expected_reports = {expected_reports, fault};
      end
      default: ;
    endcase
    if (r.req_type != REQ_RESERVED) sent_count++;
  endtask

  function automatic ttk_pkg::request_t random_request();
    ttk_pkg::request_t r;
    r.req_type     = 2'($urandom_range(0, 3));
    r.usage        = 8'($urandom_range(0, 255));
    r.plain_char   = 8'($urandom_range(0, 255));
    r.shifted_char = 8'($urandom_range(0, 255));
    r.text_char    = 8'($urandom_range(0, 255));
    r.text_end     = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Picks a character that the table currently maps, if there is one.
  function automatic logic [7:0] pick_mapped_char();
    logic [7:0] mapped [$];
    for (int c = 0; c < 256; c++) if (char_valid[c]) mapped = {mapped, c[7:0]};
    if (mapped.size() == 0) return 8'($urandom_range(0, 255));
    return mapped[$urandom_range(0, mapped.size() - 1)];
  endfunction

  // Appends one row to the directed table.
  task automatic add_row(input row_kind_t kind, input logic [1:0] req_type,
                         input logic [7:0] usage, input logic [7:0] pc,
                         input logic [7:0] sc, input logic [7:0] tc,
                         input logic fin);
    directed_row_t row;
    row.kind             = kind;
    row.req.req_type     = req_type;
    row.req.usage        = usage;
    row.req.plain_char   = pc;
    row.req.shifted_char = sc;
    row.req.text_char    = tc;
    row.req.text_end     = fin;
    directed_rows        = {directed_rows, row};
  endtask

  // A burst of keymap entries, sometimes after a table clear.
  task automatic load_random_keymap();
    ttk_pkg::request_t r;
    int                n;
    n = int'($urandom_range(4, 16));
    if ($urandom_range(0, 3) == 0) begin
      r          = random_request();
      r.req_type = ttk_pkg::REQ_CLEAR;
      send_request(r, ROW_PREDICTED);
    end
    repeat (n) begin
      r          = random_request();
      r.req_type = ttk_pkg::REQ_LOAD;
      case ($urandom_range(0, 9))
        0:          r.usage = 8'd0;
        1, 2, 3, 4: r.usage = 8'($urandom_range(1, 6));
        default:    r.usage = 8'($urandom_range(1, 255));
      endcase
      if ($urandom_range(0, 9) == 0) r.plain_char = 8'd0;
      case ($urandom_range(0, 6))
        0:       r.shifted_char = 8'd0;
        1, 2:    r.shifted_char = r.plain_char;
        default: ;
      endcase
      send_request(r, ROW_PREDICTED);
    end
  endtask

  // A text of mostly mapped characters, with repeats to exercise key release.
  task automatic type_random_text();
    ttk_pkg::request_t r;
    logic [7:0]        prev;
    int                len;
    len  = int'($urandom_range(1, 6));
    prev = pick_mapped_char();
    for (int i = 0; i < len; i++) begin
      r          = random_request();
      r.req_type = ttk_pkg::REQ_TEXT;
      case ($urandom_range(0, 9))
        0:       r.text_char = 8'($urandom_range(0, 255));
        1, 2:    r.text_char = prev;
        default: r.text_char = pick_mapped_char();
      endcase
      r.text_end = (i == len - 1);
      prev       = r.text_char;
      send_request(r, ROW_PREDICTED);
    end
  endtask

  // Checks every report against the oldest expectation.
  always @(posedge clk) begin
    ttk_pkg::report_t want;
    if (!rst && strobe === 1'b1) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual %p", $time, result);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        if (result.key_code !== want.key_code) begin
          $display("%0t: key_code expected %0h actual %0h", $time, want.key_code,
                   result.key_code);
          error_count++;
        end
        if (result.shift_down !== want.shift_down) begin
          $display("%0t: shift_down expected %0b actual %0b", $time, want.shift_down,
                   result.shift_down);
          error_count++;
        end
        if (result.failed !== want.failed) begin
          $display("%0t: failed expected %0b actual %0b", $time, want.failed, result.failed);
          error_count++;
        end
        if (result.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, result.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the length of the run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Reset, directed table, random requests, then drain.
  initial begin
    int random_goal;
    int choice;
    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    shift_held = 1'b0;
    held_key   = 8'd0;
    discarding = 1'b0;
    foreach (char_valid[c]) char_valid[c] = 1'b0;

    // Empty table, then extremes of the keymap and of the shift modes.
    add_row(ROW_FAULT,     ttk_pkg::REQ_TEXT, 8'h00, 8'h00, 8'h00, 8'h61, 1'b0);
    add_row(ROW_SILENT,    ttk_pkg::REQ_TEXT, 8'h00, 8'h00, 8'h00, 8'h62, 1'b0);
    add_row(ROW_SILENT,    ttk_pkg::REQ_TEXT, 8'h00, 8'h00, 8'h00, 8'h63, 1'b1);
    add_row(ROW_FAULT,     ttk_pkg::REQ_TEXT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    add_row(ROW_SILENT,    ttk_pkg::REQ_LOAD, 8'h04, 8'h61, 8'h41, 8'h00, 1'b0);
    add_row(ROW_SILENT,    ttk_pkg::REQ_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    add_row(ROW_SILENT,    ttk_pkg::REQ_LOAD, 8'h2C, 8'h20, 8'h20, 8'h00, 1'b0);
    add_row(ROW_SILENT,    ttk_pkg::REQ_LOAD, 8'h00, 8'h7A, 8'h5A, 8'h00, 1'b0);
    add_row(ROW_SILENT,    ttk_pkg::REQ_LOAD, 8'h05, 8'h00, 8'h80, 8'h00, 1'b0);
    add_row(ROW_SILENT,    ttk_pkg::REQ_LOAD, 8'h06, 8'h62, 8'h00, 8'h00, 1'b0);
    add_row(ROW_PREDICTED, ttk_pkg::REQ_TEXT, 8'h00, 8'h00, 8'h00, 8'h61, 1'b0);
    add_row(ROW_PREDICTED, ttk_pkg::REQ_TEXT, 8'h00, 8'h00, 8'h00, 8'h61, 1'b0);
    add_row(ROW_PREDICTED, ttk_pkg::REQ_TEXT, 8'h00, 8'h00, 8'h00, 8'h41, 1'b0);
    add_row(ROW_PREDICTED, ttk_pkg::REQ_TEXT, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
    add_row(ROW_PREDICTED, ttk_pkg::REQ_TEXT, 8'h00, 8'h00, 8'h00, 8'h62, 1'b0);
    add_row(ROW_PREDICTED, ttk_pkg::REQ_TEXT, 8'h00, 8'h00, 8'h00, 8'h80, 1'b1);
    // An entry with usage zero was ignored, so its characters stay unmapped.
    add_row(ROW_FAULT,     ttk_pkg::REQ_TEXT, 8'h00, 8'h00, 8'h00, 8'h7A, 1'b1);
    add_row(ROW_SILENT,    REQ_RESERVED,      8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    // A later entry overwrites an earlier one.
    add_row(ROW_SILENT,    ttk_pkg::REQ_LOAD, 8'h07, 8'h61, 8'h61, 8'h00, 1'b0);
    add_row(ROW_PREDICTED, ttk_pkg::REQ_TEXT, 8'h00, 8'h00, 8'h00, 8'h61, 1'b0);
    // A clear in the middle of a text leaves the text state alone.
    add_row(ROW_SILENT,    ttk_pkg::REQ_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_row(ROW_FAULT,     ttk_pkg::REQ_TEXT, 8'h00, 8'h00, 8'h00, 8'h61, 1'b0);
    add_row(ROW_SILENT,    ttk_pkg::REQ_TEXT, 8'h00, 8'h00, 8'h00, 8'h20, 1'b1);
    add_row(ROW_FAULT,     ttk_pkg::REQ_TEXT, 8'h00, 8'h00, 8'h00, 8'h5A, 1'b1);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_request(directed_rows[i].req, directed_rows[i].kind);

    // Random part: mostly keymap bursts and well-formed texts, some noise.
    random_goal = sent_count + RANDOM_ITEMS;
    load_random_keymap();
    while (sent_count < random_goal) begin
      choice = int'($urandom_range(0, 99));
      if (choice < 12) begin
        load_random_keymap();
      end else if (choice < 90) begin
        type_random_text();
      end else begin
        send_request(random_request(), ROW_PREDICTED);
      end
    end
    start <= 1'b0;

    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
